### rtl/core/sts_pkg.sv
// Shared constants, codes and types of the sorted time stamp table.
package sts_pkg;

	localparam int CAPACITY = 32;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	localparam int OP_W     = 2;
	localparam int ID_W     = 16;
	localparam int STAMP_W  = 32;
	localparam int ST_W     = 2;
	localparam int COUNT_W  = 6;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
	localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;
	localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

	localparam logic [ST_W-1:0] ST_DONE   = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL   = 2'd1;
	localparam logic [ST_W-1:0] ST_ABSENT = 2'd2;

	// Command broadcast to every cell in the execute cycle.
	typedef struct packed {
		logic               ins;
		logic               del;
		logic [ID_W-1:0]    id;
		logic [STAMP_W-1:0] key;
	} cell_cmd_t;

	// What a cell shows its neighbors.
	typedef struct packed {
		logic               valid;
		logic               at;
		logic [ID_W-1:0]    id;
		logic [STAMP_W-1:0] stamp;
	} cell_link_t;

	// Operation handed from the control to the cell row.
	typedef struct packed {
		logic               exec;
		logic [OP_W-1:0]    op;
		logic [ID_W-1:0]    id;
		logic [STAMP_W-1:0] key;
	} row_req_t;

	// Search outcome reported by the cell row.
	typedef struct packed {
		logic                found;
		logic [ID_W-1:0]     found_id;
		logic                full;
		logic [CAPACITY-1:0] valid_vec;
	} row_res_t;

endpackage

### rtl/core/sts_ifs.sv
// Valid/ready channel interfaces for operation words and result words.
interface sts_op_if;
	logic                          valid;
	logic                          ready;
	logic [sts_pkg::OP_W-1:0]      operation;
	logic [sts_pkg::ID_W-1:0]      entry_id;
	logic [sts_pkg::STAMP_W-1:0]   key_stamp;

	modport source (output valid, output operation, output entry_id, output key_stamp,
		input ready);
	modport sink (input valid, input operation, input entry_id, input key_stamp,
		output ready);
endinterface

interface sts_res_if;
	logic                          valid;
	logic                          ready;
	logic                          found;
	logic [sts_pkg::ID_W-1:0]      found_id;
	logic [sts_pkg::ST_W-1:0]      status;
	logic [sts_pkg::COUNT_W-1:0]   entry_count;

	modport source (output valid, output found, output found_id, output status,
		output entry_count, input ready);
	modport sink (input valid, input found, input found_id, input status,
		input entry_count, output ready);
endinterface

### rtl/core/sts_cell.sv
// One table cell: holds an entry, compares it to the key and shifts with its neighbors.
module sts_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  sts_pkg::cell_cmd_t  cmd,
	input  sts_pkg::cell_link_t left,
	input  sts_pkg::cell_link_t right,
	output sts_pkg::cell_link_t link,
	output logic                hit
);

	logic                        valid_q;
	logic [sts_pkg::ID_W-1:0]    id_q;
	logic [sts_pkg::STAMP_W-1:0] stamp_q;
	logic                        at_w;

	// A cell is at or past the insert/delete point when empty or not below the key.
	assign at_w = !valid_q || (stamp_q >= cmd.key);
	assign hit  = at_w && !left.at && valid_q && (stamp_q == cmd.key);

	always_comb begin
		link.valid = valid_q;
		link.at    = at_w;
		link.id    = id_q;
		link.stamp = stamp_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.ins && at_w) begin
			valid_q <= left.at ? left.valid : 1'b1;
		end else if (cmd.del && at_w) begin
			valid_q <= right.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ins && at_w) begin
			id_q    <= left.at ? left.id : cmd.id;
			stamp_q <= left.at ? left.stamp : cmd.key;
		end else if (cmd.del && at_w) begin
			id_q    <= right.id;
			stamp_q <= right.stamp;
		end
	end

endmodule

### rtl/core/sts_row.sv
// Row of table cells with the broadcast command and the match reduction.
module sts_row (
	input  logic              clk,
	input  logic              arst_n,
	input  sts_pkg::row_req_t req,
	output sts_pkg::row_res_t res
);

	sts_pkg::cell_link_t             links [sts_pkg::CAPACITY];
	sts_pkg::cell_cmd_t              cmd;
	logic [sts_pkg::CAPACITY-1:0]    hits;
	logic [sts_pkg::ID_W-1:0]        hit_id;
	logic                            full_w;

	localparam sts_pkg::cell_link_t EDGE_LINK = '0;

	assign full_w = links[sts_pkg::CAPACITY-1].valid;

	// Only one cell can hit, so the id is an OR over the gated ids.
	always_comb begin
		hit_id = '0;
		for (int i = 0; i < sts_pkg::CAPACITY; i++) begin
			hit_id = hit_id | (links[i].id & {sts_pkg::ID_W{hits[i]}});
		end
	end

	always_comb begin
		cmd.ins = req.exec && (req.op == sts_pkg::OP_INSERT) && !full_w;
		cmd.del = req.exec && (req.op == sts_pkg::OP_DELETE) && (|hits);
		cmd.id  = req.id;
		cmd.key = req.key;
	end

	for (genvar g = 0; g < sts_pkg::CAPACITY; g++) begin : g_cell
		sts_pkg::cell_link_t left_w;
		sts_pkg::cell_link_t right_w;

		if (g == 0) begin : g_first
			assign left_w = EDGE_LINK;
		end else begin : g_mid_l
			assign left_w = links[g-1];
		end

		if (g == sts_pkg::CAPACITY - 1) begin : g_last
			assign right_w = EDGE_LINK;
		end else begin : g_mid_r
			assign right_w = links[g+1];
		end

		sts_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd),
			.left   (left_w),
			.right  (right_w),
			.link   (links[g]),
			.hit    (hits[g])
		);

		assign res.valid_vec[g] = links[g].valid;
	end

	assign res.found    = |hits;
	assign res.found_id = hit_id;
	assign res.full     = full_w;

endmodule

### rtl/core/sorted_timestamp_table.sv
// Top level of the sorted time stamp table: handshakes, count and result register.
//
// The block keeps up to CAPACITY entries of (id, stamp) in ascending stamp order.
// Each word on the req channel is one operation: insert, delete by stamp or
// look up by stamp. Each operation gives exactly one word on the rsp channel
// carrying found, the id of the first matching entry, a status code and the
// entry count after the operation.
//
// The entries live in a row of identical cells. Every cell compares its stamp
// against the broadcast key in parallel; an insert shifts the cells at and past
// the insertion point one place right, a delete shifts them one place left.
// On accept the word is registered in the input register. Once the result slot
// is free, the row does the compare and shift and the result register loads.
// The block takes no new word until the held word has executed.
//
// Reset empties the table at once (every cell's valid bit clears), so no
// clearing pass is needed. A new word may be accepted while a result waits on
// rsp; that word then waits in the input register until the result is taken,
// so a stalled receiver only stops the block, never loses or repeats a word.
module sorted_timestamp_table (
	input  logic        clk,
	input  logic        arst_n,
	sts_op_if.sink      req,
	sts_res_if.source   rsp
);

	logic                           busy_q;
	logic [sts_pkg::OP_W-1:0]       op_s1;
	logic [sts_pkg::ID_W-1:0]       id_s1;
	logic [sts_pkg::STAMP_W-1:0]    key_s1;

	logic                           out_valid_q;
	logic                           found_q;
	logic [sts_pkg::ID_W-1:0]       found_id_q;
	logic [sts_pkg::ST_W-1:0]       status_q;
	logic [sts_pkg::CNT_W-1:0]      count_q;

	logic                           accept_w;
	logic                           exec_w;
	logic                           is_search_w;
	logic                           hit_w;
	logic [sts_pkg::ST_W-1:0]       status_w;
	logic [sts_pkg::CNT_W-1:0]      count_next_w;

	sts_pkg::row_req_t              row_req;
	sts_pkg::row_res_t              row_res;

	// The input register holds one word; it executes once the result slot is free.
	assign req.ready = !busy_q;
	assign accept_w  = req.valid && req.ready;
	assign exec_w    = busy_q && (!out_valid_q || rsp.ready);

	always_comb begin
		row_req.exec = exec_w;
		row_req.op   = op_s1;
		row_req.id   = id_s1;
		row_req.key  = key_s1;
	end

	sts_row u_row (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (row_req),
		.res    (row_res)
	);

	assign is_search_w = (op_s1 == sts_pkg::OP_DELETE) || (op_s1 == sts_pkg::OP_LOOKUP);
	assign hit_w       = is_search_w && row_res.found;

	// Status and the new count follow from the operation and the row's verdict.
	always_comb begin
		status_w     = sts_pkg::ST_DONE;
		count_next_w = count_q;
		unique case (op_s1)
			sts_pkg::OP_INSERT: begin
				if (row_res.full) begin
					status_w = sts_pkg::ST_FULL;
				end else begin
					count_next_w = count_q + 1'b1;
				end
			end
			sts_pkg::OP_DELETE: begin
				if (row_res.found) begin
					count_next_w = count_q - 1'b1;
				end else begin
					status_w = sts_pkg::ST_ABSENT;
				end
			end
			sts_pkg::OP_LOOKUP: begin
				if (!row_res.found) begin
					status_w = sts_pkg::ST_ABSENT;
				end
			end
			default: begin
				status_w = sts_pkg::ST_DONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			if (accept_w) begin
				busy_q <= 1'b1;
			end else if (exec_w) begin
				busy_q <= 1'b0;
			end
			if (exec_w) begin
				out_valid_q <= 1'b1;
				count_q     <= count_next_w;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept_w) begin
			op_s1  <= req.operation;
			id_s1  <= req.entry_id;
			key_s1 <= req.key_stamp;
		end
		if (exec_w) begin
			found_q    <= hit_w;
			found_id_q <= hit_w ? row_res.found_id : '0;
			status_q   <= status_w;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.found       = found_q;
	assign rsp.found_id    = found_id_q;
	assign rsp.status      = status_q;
	assign rsp.entry_count = sts_pkg::COUNT_W'(count_q);

	// The count always equals the number of occupied cells.
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == sts_pkg::CNT_W'($countones(row_res.valid_vec)))
		else $error("entry count differs from occupied cells");

	// Occupied cells form one run starting at cell zero.
	a_cells_packed: assert property (@(posedge clk) disable iff (!arst_n)
		((row_res.valid_vec + 1'b1) & row_res.valid_vec) == '0)
		else $error("occupied cells are not contiguous");

	// A result appears only from an executed operation.
	a_result_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(busy_q))
		else $error("result without a pending operation");

	// A found entry always reports a completed operation.
	a_found_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && found_q |-> status_q == sts_pkg::ST_DONE)
		else $error("found with a failing status");

	// An accepted word is held until it executes.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept_w |=> busy_q)
		else $error("accepted word not held");

endmodule

### test/testbench.sv
// Self-checking testbench for the sorted time stamp table.
`timescale 1ns / 100ps

module testbench;
	import sts_pkg::*;

	// Random words after the directed opening, and the cycle count that ends a hung run.
	localparam int RANDOM_WORDS = 1950;
	localparam int QUIET_TAIL   = 250;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int LONG_HOLD    = 80;
	localparam int MAX_REPORTS  = 10;

	// One result word as the table is expected to return it.
	typedef struct packed {
		logic               found;
		logic [ID_W-1:0]    found_id;
		logic [ST_W-1:0]    status;
		logic [COUNT_W-1:0] entry_count;
	} table_result_t;

	// Operation mixes of the random part. A fill mix pushes the table into its full
	// state, a drain mix empties it again, and an even mix stirs the middle.
	typedef enum logic [1:0] {MIX_FILL, MIX_DRAIN, MIX_EVEN} op_mix_t;

	// Shadow copy of the table. Every accepted operation word updates the shadow
	// and queues the result it must produce; every result word from the block is
	// compared against the oldest queued result.
	class stamp_table_model;
		logic [ID_W-1:0]    ids [CAPACITY];
		logic [STAMP_W-1:0] stamps [CAPACITY];
		int                 count;
		table_result_t      pending_results [$];
		int                 errors;

		function new();
			count = 0;
			errors = 0;
		endfunction

		// Position of the first held entry whose stamp is not below the key.
		function int first_not_below(logic [STAMP_W-1:0] key);
			for (int i = 0; i < count; i++) begin
				if (stamps[i] >= key) return i;
			end
			return count;
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		function void note_word(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
			logic [STAMP_W-1:0] key);
			table_result_t r;
			int            pos;
			r = '0;
			case (op)
				OP_INSERT: begin
					if (count >= CAPACITY) begin
						r.status = ST_FULL;
					end else begin
						// Inserted ahead of any entry with an equal stamp.
						pos = first_not_below(key);
						for (int i = count; i > pos; i--) begin
							ids[i] = ids[i-1];
							stamps[i] = stamps[i-1];
						end
						ids[pos] = id;
						stamps[pos] = key;
						count++;
					end
				end
				OP_DELETE, OP_LOOKUP: begin
					pos = first_not_below(key);
					if (pos < count && stamps[pos] == key) begin
						r.found = 1'b1;
						r.found_id = ids[pos];
						if (op == OP_DELETE) begin
							for (int i = pos; i + 1 < count; i++) begin
								ids[i] = ids[i+1];
								stamps[i] = stamps[i+1];
							end
							count--;
						end
					end else begin
						r.status = ST_ABSENT;
					end
				end
				default: begin
				end
			endcase
			r.entry_count = count[COUNT_W-1:0];
			pending_results.push_back(r);
		endfunction

		function void check_result(table_result_t got);
			table_result_t want;
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("Result word with none expected: found=%0d id=%h status=%0d count=%0d",
						got.found, got.found_id, got.status, got.entry_count);
				return;
			end
			want = pending_results.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("Mismatch: expected found=%0d id=%h status=%0d count=%0d, got found=%0d id=%h status=%0d count=%0d",
						want.found, want.found_id, want.status, want.entry_count,
						got.found, got.found_id, got.status, got.entry_count);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	sts_op_if  req ();
	sts_res_if rsp ();

	sorted_timestamp_table dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	stamp_table_model model = new();

	// Words accepted so far; the receiver uses it to time its long hold-off.
	int accepted_words = 0;
	// Set for the tail of the run, where neither side idles.
	bit quiet_tail = 1'b0;
	int cycle_count = 0;

	// Clock with a 4 ns period.
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Result words are sampled at the rising edge, where a transfer takes place.
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready)
			model.check_result({rsp.found, rsp.found_id, rsp.status, rsp.entry_count});
	end

	// Watchdog: a hung handshake ends the run as a failure.
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Verification failed");
		$finish;
	end

	// Receiver. It stalls in short random bursts, except in the quiet tail, and
	// once holds ready low for a long stretch while the sender keeps offering
	// words, so that the input register and the result register both fill and
	// the block has to stall its input.
	initial begin : receiver
		bit held;
		held = 1'b0;
		rsp.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && accepted_words >= 300) begin
				held = 1'b1;
				rsp.ready <= 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
			end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
				rsp.ready <= 1'b0;
				repeat ($urandom_range(1, 3) - 1) @(negedge clk);
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	// Offers one operation word and returns at the falling edge after it was
	// accepted. It is entered at a falling edge. A random gap with valid low may
	// come first, outside the quiet tail.
	task automatic send_word(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
		logic [STAMP_W-1:0] key);
		if (!quiet_tail && $urandom_range(0, 4) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		req.valid <= 1'b1;
		req.operation <= op;
		req.entry_id <= id;
		req.key_stamp <= key;
		do @(posedge clk); while (!req.ready);
		model.note_word(op, id, key);
		accepted_words++;
		@(negedge clk);
	endtask

	// Operation choice for a mix; the unused code turns up now and then.
	function automatic logic [OP_W-1:0] pick_op(op_mix_t mix);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 3) return OP_NONE;
		case (mix)
			MIX_FILL:  return (roll < 72) ? OP_INSERT : (roll < 86) ? OP_DELETE : OP_LOOKUP;
			MIX_DRAIN: return (roll < 18) ? OP_INSERT : (roll < 82) ? OP_DELETE : OP_LOOKUP;
			default:   return (roll < 45) ? OP_INSERT : (roll < 72) ? OP_DELETE : OP_LOOKUP;
		endcase
	endfunction

	// Stamp choice. Stamps already held make deletes and lookups hit and make
	// inserts pile up duplicates; a small range makes near neighbors; the
	// extremes check unsigned ordering; the rest is uniform over 32 bits.
	function automatic logic [STAMP_W-1:0] pick_stamp();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 40 && model.count > 0)
			return model.stamps[$urandom_range(0, model.count - 1)];
		if (roll < 70)
			return STAMP_W'($urandom_range(0, 15));
		if (roll < 80) begin
			case ($urandom_range(0, 3))
				0:       return '0;
				1:       return '1;
				2:       return 32'h8000_0000;
				default: return 32'h7FFF_FFFF;
			endcase
		end
		return $urandom();
	endfunction

	// Stimulus and end of run.
	initial begin : sender
		op_mix_t mix;
		int      phase_left;
		arst_n = 1'b0;
		req.valid <= 1'b0;
		req.operation <= OP_NONE;
		req.entry_id <= '0;
		req.key_stamp <= '0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed opening: empty table, the unused code, extreme ids and stamps,
		// unsigned order across the top bit, and duplicate stamps where insert
		// goes ahead of its equals and delete takes only the first match.
		send_word(OP_LOOKUP, 16'h0000, 32'h0000_0000);
		send_word(OP_DELETE, 16'hFFFF, 32'hFFFF_FFFF);
		send_word(OP_NONE,   16'hFFFF, 32'hFFFF_FFFF);
		send_word(OP_INSERT, 16'h0000, 32'h0000_0000);
		send_word(OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
		send_word(OP_INSERT, 16'h1234, 32'h8000_0000);
		send_word(OP_INSERT, 16'h0001, 32'h0000_0005);
		send_word(OP_INSERT, 16'h0002, 32'h0000_0005);
		send_word(OP_INSERT, 16'h0003, 32'h0000_0005);
		send_word(OP_LOOKUP, 16'hFFFF, 32'h0000_0005);
		send_word(OP_DELETE, 16'h0000, 32'h0000_0005);
		send_word(OP_LOOKUP, 16'h0000, 32'h0000_0005);
		send_word(OP_LOOKUP, 16'h0000, 32'h0000_0006);
		send_word(OP_LOOKUP, 16'h0000, 32'h0000_0004);
		send_word(OP_LOOKUP, 16'h0000, 32'hFFFF_FFFF);
		send_word(OP_LOOKUP, 16'h0000, 32'h7FFF_FFFF);
		send_word(OP_DELETE, 16'h0000, 32'h0000_0000);
		send_word(OP_LOOKUP, 16'h0000, 32'h0000_0000);
		send_word(OP_NONE,   16'h0000, 32'h0000_0000);
		send_word(OP_DELETE, 16'h0000, 32'h8000_0000);
		send_word(OP_DELETE, 16'h0000, 32'h0000_0005);
		send_word(OP_DELETE, 16'h0000, 32'h0000_0005);
		send_word(OP_DELETE, 16'h0000, 32'h0000_0005);
		send_word(OP_DELETE, 16'h0000, 32'hFFFF_FFFF);
		send_word(OP_INSERT, 16'hAAAA, 32'h5555_5555);

		// Random part in phases of changing mix, so the table swings between
		// empty and full many times and full-table inserts come up often.
		mix = MIX_FILL;
		phase_left = $urandom_range(40, 120);
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n >= RANDOM_WORDS - QUIET_TAIL) quiet_tail = 1'b1;
			if (phase_left == 0) begin
				case ($urandom_range(0, 2))
					0:       mix = MIX_FILL;
					1:       mix = MIX_DRAIN;
					default: mix = MIX_EVEN;
				endcase
				phase_left = $urandom_range(40, 120);
			end
			phase_left--;
			// Once in the middle the sender stops until every result is back.
			if (n == RANDOM_WORDS / 2) begin
				req.valid <= 1'b0;
				do @(negedge clk); while (model.pending() != 0);
			end
			send_word(pick_op(mix), ID_W'($urandom()), pick_stamp());
		end
		req.valid <= 1'b0;

		// Drain, then a short tail to catch any stray result word.
		while (model.pending() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (model.errors == 0 && model.pending() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
